// ===== hdl/qssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qssd_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_KEY   = 3'd0,
    KIND_VAL   = 3'd1,
    KIND_END   = 3'd2,
    KIND_REKEY = 3'd3,
    KIND_ERR   = 3'd4
  } kind_t;

  // escape sequencing; code 3 is handled as no escape pending
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HI   = 2'd1,
    ESC_LO   = 2'd2
  } esc_t;

  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_PCT        = 8'h25;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_PRINT_LO   = 8'h21;
  localparam logic [7:0] CH_PRINT_HI   = 8'h7E;

  localparam int unsigned RES_FIFO_DEPTH = 4;
  localparam int unsigned RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned RES_CNT_W      = RES_PTR_W + 1;

  typedef struct packed {
    logic       in_value;
    esc_t       esc;
    logic [3:0] high_nibble;
    logic       dropping;
  } parse_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       eos;
  } result_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/qssd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qssd_decode (
  input  wire logic [7:0]            char_in,
  input  wire logic                  is_last,
  input  wire qssd_pkg::parse_state_t st,
  output qssd_pkg::parse_state_t     st_nxt,
  output logic [1:0]                 res_cnt,
  output qssd_pkg::result_t          res0,
  output qssd_pkg::result_t          res1
);
  import qssd_pkg::*;

  kind_t      byte_kind;
  logic       err;
  logic [4:0] hv;

  assign byte_kind = st.in_value ? KIND_VAL : KIND_KEY;
  assign hv        = hex_value(char_in);

  always_comb begin
    st_nxt  = st;
    res_cnt = 2'd0;
    res0    = '{kind: KIND_KEY, ch: 8'h00, eos: 1'b0};
    res1    = '{kind: KIND_KEY, ch: 8'h00, eos: 1'b0};
    err     = 1'b0;

    if (st.dropping) begin
      if (is_last) st_nxt = '0;
    end else begin
      case (st.esc)
        ESC_HI, ESC_LO: begin
          if (hv[4]) begin
            err = 1'b1;
          end else if (st.esc == ESC_HI) begin
            if (is_last) begin
              err = 1'b1;
            end else begin
              st_nxt.high_nibble = hv[3:0];
              st_nxt.esc         = ESC_LO;
            end
          end else begin
            res0               = '{kind: byte_kind, ch: {st.high_nibble, hv[3:0]}, eos: 1'b0};
            res_cnt            = 2'd1;
            st_nxt.esc         = ESC_NONE;
            st_nxt.high_nibble = 4'd0;
          end
        end
        default: begin
          st_nxt.esc = ESC_NONE;
          if (char_in inside {CH_AMP, CH_SEMI}) begin
            res0            = '{kind: KIND_END, ch: 8'h00, eos: 1'b0};
            res_cnt         = 2'd1;
            st_nxt.in_value = 1'b0;
          end else if (char_in == CH_EQ) begin
            if (st.in_value) begin
              res0    = '{kind: KIND_REKEY, ch: 8'h00, eos: 1'b0};
              res_cnt = 2'd1;
            end else begin
              st_nxt.in_value = 1'b1;
            end
          end else if (char_in == CH_PLUS) begin
            res0    = '{kind: byte_kind, ch: CH_SPACE, eos: 1'b0};
            res_cnt = 2'd1;
          end else if (char_in == CH_PCT) begin
            if (is_last) err = 1'b1;
            else st_nxt.esc = ESC_HI;
          end else if (char_in inside {CH_HASH, CH_SPACE} ||
                       !(char_in inside {[CH_PRINT_LO:CH_PRINT_HI]})) begin
            err = 1'b1;
          end else begin
            res0    = '{kind: byte_kind, ch: char_in, eos: 1'b0};
            res_cnt = 2'd1;
          end
        end
      endcase

      if (err) begin
        // one error result replaces anything else from this byte
        res0    = '{kind: KIND_ERR, ch: 8'h00, eos: is_last};
        res_cnt = 2'd1;
        if (is_last) st_nxt = '0;
        else st_nxt.dropping = 1'b1;
      end else if (is_last) begin
        if (res_cnt == 2'd0) begin
          res0 = '{kind: KIND_END, ch: 8'h00, eos: 1'b1};
        end else begin
          res1 = '{kind: KIND_END, ch: 8'h00, eos: 1'b1};
        end
        res_cnt = res_cnt + 2'd1;
        st_nxt  = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qssd_result_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qssd_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        push_cnt,
  input  wire qssd_pkg::result_t push0,
  input  wire qssd_pkg::result_t push1,
  output logic                   room2,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output qssd_pkg::result_t      out_res
);
  import qssd_pkg::*;

  result_t                mem_r [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0]   count_r, count_nxt;
  logic                   pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign room2     = (count_r <= RES_CNT_W'(RES_FIFO_DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    count_nxt  = count_r + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_r + RES_PTR_W'(1)] <= push1;
  end

endmodule

`default_nettype wire

// ===== hdl/query_string_splitter_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Query string splitter / decoder.
// Input stream: one raw byte of a form-urlencoded query string per item,
//   in_tdata = byte, in_tlast marks the final byte of the string.
// Output stream: decoded items, out_tuser = kind (key byte, value byte,
//   pair end, value-becomes-key, error), out_tdata = decoded byte (zero
//   for non-byte kinds), out_tlast on the final item made from the last byte.
// Each byte yields zero, one or two items; two only on the last byte
//   (data byte or separator plus the closing pair end).
// Parse state updates in the cycle the byte is taken; results land in a
//   four-entry result queue whose head drives the output.
// Throughput: one byte per cycle while the receiver keeps up; in_tready
//   drops whenever fewer than two queue slots are free.
// Reset (rst_n low, synchronous) clears the parse state and empties the
//   queue. When the receiver stalls, queued items hold and input stops
//   once the queue is nearly full; nothing is lost.
// After an error, bytes are swallowed up to and including the last one.

module query_string_splitter_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] char_out
  output logic [2:0]      out_tuser,  // [2:0] kind
  output logic            out_tlast
);
  import qssd_pkg::*;

  parse_state_t st_r, st_nxt;
  logic [1:0]   res_cnt;
  logic [1:0]   push_cnt;
  result_t      res0, res1, head;
  logic         room2;
  logic         in_accept;

  assign in_tready = room2;
  assign in_accept = in_tvalid && in_tready;
  assign push_cnt  = in_accept ? res_cnt : 2'd0;

  qssd_decode u_decode (
    .char_in (in_tdata),
    .is_last (in_tlast),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  // parse state advances only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  qssd_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tdata = head.ch;
  assign out_tuser = head.kind;
  assign out_tlast = head.eos;

endmodule

`default_nettype wire
